### src/mt_pkg.sv
// Package for the MT19937 word generator: pool geometry, seeding and
// twist/temper constants. No dependencies.
package mt_pkg;

  localparam int unsigned STATE_DEPTH = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned IDX_W = $clog2(STATE_DEPTH);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [31:0] word_t;

  localparam idx_t LAST_IDX = idx_t'(STATE_DEPTH - 1);

  localparam word_t TWIST_MATRIX = 32'h9908_b0df;
  localparam word_t TEMPER_B = 32'h9d2c_5680;
  localparam word_t TEMPER_C = 32'hefc6_0000;
  localparam word_t LCG_MULT = 32'd69069;
  localparam word_t SEED_RESET = 32'd4357;

endpackage

### src/mt_temper.sv
// Output tempering of one MT19937 state word.
// Uses mt_pkg for the tempering masks.
module mt_temper (
  input  mt_pkg::word_t word_i,
  output mt_pkg::word_t word_o
);

  mt_pkg::word_t y1, y2, y3;

  assign y1 = word_i ^ (word_i >> 11);
  assign y2 = y1 ^ ((y1 << 7) & mt_pkg::TEMPER_B);
  assign y3 = y2 ^ ((y2 << 15) & mt_pkg::TEMPER_C);
  assign word_o = y3 ^ (y3 >> 18);

endmodule

### src/mersenne_twister_generator.sv
// MT19937 generator, top level. Depends on mt_pkg and mt_temper.
// Per word: request transfer and state memory read (two ports) in IDLE, then
// twist and write in DRAW; the result registers when DRAW completes, held off by
// a stalled valid output; no new request is taken before. Seeding (first request
// after reset, or restart) adds FILL_HI/FILL_LO, two LCG multiplies per pool word,
// then ISSUE for the read. Reset: seed = 4357, pool unseeded, memory not cleared.
module mersenne_twister_generator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  mt_pkg::word_t cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          restart_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mt_pkg::word_t random_word_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL_HI,
    ST_FILL_LO,
    ST_ISSUE,
    ST_DRAW
  } state_e;

  state_e state_q;
  mt_pkg::word_t seed_q, s_q, cur_q, out_word_q;
  logic [15:0] hi_q;
  mt_pkg::idx_t index_q;
  logic seeded_q, out_valid_q;

  mt_pkg::word_t mem_q [mt_pkg::STATE_DEPTH];
  mt_pkg::word_t rd_a_q, rd_b_q;
  mt_pkg::idx_t addr_a, addr_b, wr_addr;
  mt_pkg::word_t wr_data;
  logic wr_en;

  logic [mt_pkg::IDX_W:0] far_sum;
  mt_pkg::word_t lcg_next, fill_word, twist_y, twist_word, tempered;
  logic in_xfer, draw_done;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer = in_valid_i && !in_stall_o;
  assign draw_done = (state_q == ST_DRAW) && !(out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign random_word_o = out_word_q;

  assign addr_a = (index_q == mt_pkg::LAST_IDX) ? '0 : index_q + mt_pkg::idx_t'(1);
  assign far_sum = {1'b0, index_q} + (mt_pkg::IDX_W+1)'(mt_pkg::TWIST_OFFSET);
  assign addr_b = (far_sum >= (mt_pkg::IDX_W+1)'(mt_pkg::STATE_DEPTH))
                ? mt_pkg::idx_t'(far_sum - (mt_pkg::IDX_W+1)'(mt_pkg::STATE_DEPTH))
                : mt_pkg::idx_t'(far_sum);

  assign lcg_next = s_q * mt_pkg::LCG_MULT + 32'd1;
  assign fill_word = {hi_q, s_q[31:16]};

  assign twist_y = {cur_q[31], rd_a_q[30:0]};
  assign twist_word = rd_b_q ^ (twist_y >> 1) ^ (twist_y[0] ? mt_pkg::TWIST_MATRIX : '0);

  mt_temper u_temper (
    .word_i(twist_word),
    .word_o(tempered)
  );

  always_comb begin
    wr_en = 1'b0;
    wr_addr = index_q;
    wr_data = twist_word;
    if (state_q == ST_FILL_LO) begin
      wr_en = 1'b1;
      wr_data = fill_word;
    end else if (draw_done) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_a_q <= mem_q[addr_a];
    rd_b_q <= mem_q[addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seed_q <= mt_pkg::SEED_RESET;
      seeded_q <= 1'b0;
      index_q <= '0;
      out_valid_q <= 1'b0;
      s_q <= '0;
      hi_q <= '0;
      cur_q <= '0;
      out_word_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        seed_q <= cfg_data_i;
      end
      if (draw_done) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (restart_i || !seeded_q) begin
              seeded_q <= 1'b1;
              s_q <= seed_q;
              index_q <= '0;
              state_q <= ST_FILL_HI;
            end else begin
              state_q <= ST_DRAW;
            end
          end
        end
        ST_FILL_HI: begin
          hi_q <= s_q[31:16];
          s_q <= lcg_next;
          state_q <= ST_FILL_LO;
        end
        ST_FILL_LO: begin
          s_q <= lcg_next;
          if (index_q == '0) begin
            cur_q <= fill_word;
          end
          if (index_q == mt_pkg::LAST_IDX) begin
            index_q <= '0;
            state_q <= ST_ISSUE;
          end else begin
            index_q <= index_q + mt_pkg::idx_t'(1);
            state_q <= ST_FILL_HI;
          end
        end
        ST_ISSUE: begin
          state_q <= ST_DRAW;
        end
        ST_DRAW: begin
          if (draw_done) begin
            out_word_q <= tempered;
            cur_q <= rd_a_q;
            index_q <= addr_a;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
